/* hdl/battery_level_outlier_filter_unit_assert.svh */
// assertion macros for the battery level outlier filter
`ifndef BATTERY_LEVEL_OUTLIER_FILTER_UNIT_ASSERT_SVH
`define BATTERY_LEVEL_OUTLIER_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define BLOF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blof assertion failed");
// next-cycle implication, checked out of reset
`define BLOF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blof assertion failed");
`else
`define BLOF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BLOF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/blof_pkg.sv */
// shared constants and types of the battery level outlier filter
package blof_pkg;

    localparam int WINDOW_DEPTH  = 5;
    localparam int PARTIAL_DEPTH = 4;
    localparam int SAMPLE_W      = 8;
    localparam int IDX_W         = 3;
    localparam int ACC_W         = 11;
    localparam int CFG_IDX_W     = 2;

    // floor(x / 5) = (x * 3277) >> 14 for x up to 1275
    localparam int DIV5_MUL   = 3277;
    localparam int DIV5_MUL_W = 12;
    localparam int DIV5_SHIFT = 14;

    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD    = 2'd2;

    localparam logic [1:0] ALARM_NONE = 2'd0;
    localparam logic [1:0] ALARM_WARN = 2'd1;
    localparam logic [1:0] ALARM_STOP = 2'd2;

    localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 8'd5;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic [ACC_W-1:0] c;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             lt;
    } alu_rsp_t;

endpackage

/* hdl/battery_level_outlier_filter_unit.sv */
// top level of the battery level outlier filter: sequencer, window, registers
// steps: while the window fills, sum and divide; once full, load, scan high and low, clamp
// high and low, sum, divide, stop compare and warning compare (skipped on a stop alarm)
// the input stalls from accept until the result goes to the output register, which waits
// on out_stall; the single add/compare unit serves scan, clamp, sum and alarm steps
// reset (rst_n low, asynchronous) clears window, slot, average and loads register defaults
module battery_level_outlier_filter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // input item channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [blof_pkg::SAMPLE_W-1:0]      sample,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         alarm,
    output logic [blof_pkg::SAMPLE_W-1:0]      level,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [blof_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [blof_pkg::SAMPLE_W-1:0]      cfg_data
);

`include "battery_level_outlier_filter_unit_assert.svh"

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN_HI,
        ST_SCAN_LO,
        ST_CLAMP_HI,
        ST_CLAMP_LO,
        ST_SUM,
        ST_DIV,
        ST_ALARM_STOP,
        ST_ALARM_WARN,
        ST_FINISH
    } state_t;

    localparam logic [blof_pkg::IDX_W-1:0] IDX_LAST_FULL =
        blof_pkg::IDX_W'(blof_pkg::WINDOW_DEPTH - 1);
    localparam logic [blof_pkg::IDX_W-1:0] IDX_LAST_PART =
        blof_pkg::IDX_W'(blof_pkg::PARTIAL_DEPTH - 1);
    localparam int PROD_W = blof_pkg::ACC_W + blof_pkg::DIV5_MUL_W;

    // five-entry sample ring
    logic [blof_pkg::SAMPLE_W-1:0] window_reg [blof_pkg::WINDOW_DEPTH];

    state_t                         state_reg,     state_next;
    logic [blof_pkg::IDX_W-1:0]     idx_reg,       idx_next;
    logic [blof_pkg::IDX_W-1:0]     slot_reg,      slot_next;
    logic                           full_reg,      full_next;
    logic [blof_pkg::SAMPLE_W-1:0]  avg_reg,       avg_next;
    logic [blof_pkg::SAMPLE_W-1:0]  limit_reg,     limit_next;
    logic [blof_pkg::SAMPLE_W-1:0]  warn_reg,      warn_next;
    logic [blof_pkg::SAMPLE_W-1:0]  stop_reg,      stop_next;
    logic [blof_pkg::IDX_W-1:0]     hi_idx_reg,    hi_idx_next;
    logic [blof_pkg::IDX_W-1:0]     lo_idx_reg,    lo_idx_next;
    logic [blof_pkg::SAMPLE_W-1:0]  max_val_reg,   max_val_next;
    logic [blof_pkg::SAMPLE_W-1:0]  min_val_reg,   min_val_next;
    logic [blof_pkg::ACC_W-1:0]     acc_reg,       acc_next;
    logic [blof_pkg::SAMPLE_W-1:0]  sample_reg,    sample_next;
    logic [1:0]                     alarm_calc_reg, alarm_calc_next;
    logic                           out_valid_reg, out_valid_next;
    logic [1:0]                     alarm_reg,     alarm_next;
    logic [blof_pkg::SAMPLE_W-1:0]  level_reg,     level_next;

    // single window write port
    logic                           wr_en;
    logic [blof_pkg::IDX_W-1:0]     wr_idx;
    logic [blof_pkg::SAMPLE_W-1:0]  wr_data;

    logic [blof_pkg::SAMPLE_W-1:0]  rd_data;
    logic [blof_pkg::IDX_W-1:0]     slot_eff;
    logic [PROD_W-1:0]              prod;

    blof_pkg::alu_req_t alu_req;
    blof_pkg::alu_rsp_t alu_rsp;

    blof_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // one read address into the ring, driven by the sequencer counter
    assign rd_data = window_reg[idx_reg];

    // a slot that somehow left the ring falls back to entry 0
    assign slot_eff = (slot_reg < blof_pkg::IDX_W'(blof_pkg::WINDOW_DEPTH)) ? slot_reg : '0;

    // divide by five via reciprocal multiply
    assign prod = PROD_W'(acc_reg) * PROD_W'(blof_pkg::DIV5_MUL);

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign alarm     = alarm_reg;
    assign level     = level_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        full_next       = full_reg;
        avg_next        = avg_reg;
        limit_next      = limit_reg;
        warn_next       = warn_reg;
        stop_next       = stop_reg;
        hi_idx_next     = hi_idx_reg;
        lo_idx_next     = lo_idx_reg;
        max_val_next    = max_val_reg;
        min_val_next    = min_val_reg;
        acc_next        = acc_reg;
        sample_next     = sample_reg;
        alarm_calc_next = alarm_calc_reg;
        alarm_next      = alarm_reg;
        level_next      = level_reg;
        wr_en           = 1'b0;
        wr_idx          = slot_eff;
        wr_data         = sample;
        alu_req         = '0;

        // result leaves when the consumer takes it
        out_valid_next = out_valid_reg && out_stall;

        // configuration writes, only to be issued while idle by the user; the block does not enforce it
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                blof_pkg::REG_OUTLIER_LIMIT:     limit_next = cfg_data;
                blof_pkg::REG_WARNING_THRESHOLD: warn_next  = cfg_data;
                blof_pkg::REG_STOP_THRESHOLD:    stop_next  = cfg_data;
                default:                         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    // store the sample and advance the ring slot
                    wr_en       = 1'b1;
                    wr_idx      = slot_eff;
                    wr_data     = sample;
                    sample_next = sample;
                    idx_next    = '0;
                    acc_next    = '0;
                    if (slot_eff == IDX_LAST_FULL)
                    begin
                        slot_next  = '0;
                        full_next  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        slot_next  = slot_eff + 1'b1;
                        state_next = full_reg ? ST_LOAD : ST_SUM;
                    end
                end
            end
            ST_LOAD:
            begin
                // entry 0 seeds both extremes
                max_val_next = rd_data;
                min_val_next = rd_data;
                hi_idx_next  = '0;
                lo_idx_next  = '0;
                idx_next     = blof_pkg::IDX_W'(1);
                state_next   = ST_SCAN_HI;
            end
            ST_SCAN_HI:
            begin
                // strictly greater keeps the first highest entry
                alu_req.a = blof_pkg::ACC_W'(max_val_reg);
                alu_req.c = blof_pkg::ACC_W'(rd_data);
                if (alu_rsp.lt)
                begin
                    max_val_next = rd_data;
                    hi_idx_next  = idx_reg;
                end
                if (idx_reg == IDX_LAST_FULL)
                begin
                    idx_next   = blof_pkg::IDX_W'(1);
                    state_next = ST_SCAN_LO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN_LO:
            begin
                // strictly smaller keeps the first lowest entry
                alu_req.a = blof_pkg::ACC_W'(rd_data);
                alu_req.c = blof_pkg::ACC_W'(min_val_reg);
                if (alu_rsp.lt)
                begin
                    min_val_next = rd_data;
                    lo_idx_next  = idx_reg;
                end
                if (idx_reg == IDX_LAST_FULL)
                begin
                    state_next = ST_CLAMP_HI;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CLAMP_HI:
            begin
                // max > avg + limit
                alu_req.a = blof_pkg::ACC_W'(avg_reg);
                alu_req.b = blof_pkg::ACC_W'(limit_reg);
                alu_req.c = blof_pkg::ACC_W'(max_val_reg);
                if (alu_rsp.lt)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = hi_idx_reg;
                    wr_data = avg_reg;
                    // lower test must see the replaced value on a shared entry
                    if (lo_idx_reg == hi_idx_reg)
                    begin
                        min_val_next = avg_reg;
                    end
                end
                state_next = ST_CLAMP_LO;
            end
            ST_CLAMP_LO:
            begin
                // min + limit < avg, same as min < avg - limit without going negative
                alu_req.a = blof_pkg::ACC_W'(min_val_reg);
                alu_req.b = blof_pkg::ACC_W'(limit_reg);
                alu_req.c = blof_pkg::ACC_W'(avg_reg);
                if (alu_rsp.lt)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = lo_idx_reg;
                    wr_data = avg_reg;
                end
                idx_next   = '0;
                acc_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // accumulate one entry a cycle
                alu_req.a = acc_reg;
                alu_req.b = blof_pkg::ACC_W'(rd_data);
                acc_next  = alu_rsp.sum;
                if (idx_reg == (full_reg ? IDX_LAST_FULL : IDX_LAST_PART))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (full_reg)
                begin
                    avg_next   = prod[blof_pkg::DIV5_SHIFT +: blof_pkg::SAMPLE_W];
                    state_next = ST_ALARM_STOP;
                end
                else
                begin
                    // partial window: floor of sum over four
                    avg_next        = acc_reg[2 +: blof_pkg::SAMPLE_W];
                    alarm_calc_next = blof_pkg::ALARM_NONE;
                    state_next      = ST_FINISH;
                end
            end
            ST_ALARM_STOP:
            begin
                // stop < avg fails means avg <= stop
                alu_req.a = blof_pkg::ACC_W'(stop_reg);
                alu_req.c = blof_pkg::ACC_W'(avg_reg);
                if (!alu_rsp.lt)
                begin
                    alarm_calc_next = blof_pkg::ALARM_STOP;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ALARM_WARN;
                end
            end
            ST_ALARM_WARN:
            begin
                alu_req.a       = blof_pkg::ACC_W'(avg_reg);
                alu_req.c       = blof_pkg::ACC_W'(warn_reg);
                alarm_calc_next = alu_rsp.lt ? blof_pkg::ALARM_WARN : blof_pkg::ALARM_NONE;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hand off once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    alarm_next     = alarm_calc_reg;
                    level_next     = full_reg ? avg_reg : sample_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            slot_reg       <= '0;
            full_reg       <= 1'b0;
            avg_reg        <= '0;
            limit_reg      <= blof_pkg::LIMIT_RESET;
            warn_reg       <= '0;
            stop_reg       <= '0;
            hi_idx_reg     <= '0;
            lo_idx_reg     <= '0;
            alarm_calc_reg <= blof_pkg::ALARM_NONE;
            out_valid_reg  <= 1'b0;
            alarm_reg      <= blof_pkg::ALARM_NONE;
            level_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            slot_reg       <= slot_next;
            full_reg       <= full_next;
            avg_reg        <= avg_next;
            limit_reg      <= limit_next;
            warn_reg       <= warn_next;
            stop_reg       <= stop_next;
            hi_idx_reg     <= hi_idx_next;
            lo_idx_reg     <= lo_idx_next;
            alarm_calc_reg <= alarm_calc_next;
            out_valid_reg  <= out_valid_next;
            alarm_reg      <= alarm_next;
            level_reg      <= level_next;
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        max_val_reg <= max_val_next;
        min_val_reg <= min_val_next;
        acc_reg     <= acc_next;
        sample_reg  <= sample_next;
    end

    // ring storage, cleared by reset since the window starts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < blof_pkg::WINDOW_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            window_reg[wr_idx] <= wr_data;
        end
    end

    // an accepted item lands in the slot that was current
    `BLOF_ASSERT_NEXT(a_sample_stored, clk, rst_n, in_valid && !in_stall, window_reg[$past(slot_reg)] == $past(sample))
    // an accepted item blocks the input until its result is out
    `BLOF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // the scan leaves a consistent pair of extremes
    `BLOF_ASSERT_IMPL(a_extremes_ordered, clk, rst_n, state_reg == ST_CLAMP_HI, min_val_reg <= max_val_reg)
    // a stop alarm only goes out with a level at or below the stop threshold
    `BLOF_ASSERT_IMPL(a_stop_level, clk, rst_n, out_valid_reg && alarm_reg == blof_pkg::ALARM_STOP, level_reg <= stop_reg)

endmodule

/* hdl/blof_alu.sv */
// shared add and compare unit: sum = a + b, lt = (a + b) < c
module blof_alu (
    input  blof_pkg::alu_req_t req,
    output blof_pkg::alu_rsp_t rsp
);

    logic [blof_pkg::ACC_W-1:0] sum;

    assign sum     = req.a + req.b;
    assign rsp.sum = sum;
    assign rsp.lt  = (sum < req.c);

endmodule
